// ===== hw/rtl/png_csp_pkg.sv =====
// ----------------------------------------------------------------------------
// PNG chunk stream parser package
// Report kinds, the result record, the signature bytes and the known chunk
// type table with its classifier.
// ----------------------------------------------------------------------------
package png_csp_pkg;

  typedef enum logic [1:0] {
    KIND_CHUNK  = 2'd0,
    KIND_SHORT  = 2'd1,
    KIND_BADSIG = 2'd2,
    KIND_TRUNC  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       report_kind;
    logic [4:0]  type_code;
    logic [31:0] type_word;
    logic [31:0] chunk_length;
  } result_t;

  localparam int unsigned SigLen   = 8;
  localparam int unsigned NumKnown = 18;
  localparam logic [4:0]  IendCode = 5'd3;

  localparam logic [7:0] SigBytes [SigLen] = '{
    8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10
  };

  localparam logic [31:0] KnownTypes [NumKnown] = '{
    32'h49484452, 32'h504C5445, 32'h49444154, 32'h49454E44, // IHDR PLTE IDAT IEND
    32'h6348524D, 32'h67414D41, 32'h69434350, 32'h73424954, // cHRM gAMA iCCP sBIT
    32'h73524742, 32'h624B4744, 32'h68495354, 32'h74524E53, // sRGB bKGD hIST tRNS
    32'h70485973, 32'h73504C54, 32'h74494D45, 32'h69545874, // pHYs sPLT tIME iTXt
    32'h74455874, 32'h7A545874                              // tEXt zTXt
  };

  // Parallel compare against every known type; unknown maps past the table
  function automatic logic [4:0] classify(input logic [31:0] word);
    logic [4:0] code;
    code = 5'(NumKnown);
    for (int i = NumKnown - 1; i >= 0; i--) begin
      if (word == KnownTypes[i]) begin
        code = 5'(i);
      end
    end
    return code;
  endfunction

endpackage

// ===== hw/rtl/png_csp_in_if.sv =====
// ----------------------------------------------------------------------------
// PNG chunk stream parser input channel
// One file byte or an end-of-file marker per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface png_csp_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

// ===== hw/rtl/png_csp_out_if.sv =====
// ----------------------------------------------------------------------------
// PNG chunk stream parser report channel
// One report item per handshake: kind, type code, raw type and length.
// ----------------------------------------------------------------------------
interface png_csp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  report_kind;
  logic [4:0]  type_code;
  logic [31:0] type_word;
  logic [31:0] chunk_length;

  modport source (output valid, output report_kind, output type_code,
                  output type_word, output chunk_length, input ready);
  modport sink   (input valid, input report_kind, input type_code,
                  input type_word, input chunk_length, output ready);
endinterface

// ===== hw/rtl/png_csp_skid.sv =====
// ----------------------------------------------------------------------------
// PNG chunk stream parser output buffer
// Two-entry skid buffer: an output register plus one spare entry, so the
// upstream ready is a plain register output.
// ----------------------------------------------------------------------------
module png_csp_skid (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  png_csp_pkg::result_t push_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output png_csp_pkg::result_t out_data_o
);

  logic                 main_valid_q, main_valid_d;
  logic                 skid_valid_q, skid_valid_d;
  png_csp_pkg::result_t main_q, main_d;
  png_csp_pkg::result_t skid_q, skid_d;
  logic                 pop;

  assign pop          = main_valid_q && out_ready_i;
  assign push_ready_o = !skid_valid_q;
  assign out_valid_o  = main_valid_q;
  assign out_data_o   = main_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      // upstream is held off; drain the spare entry first
      if (pop) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_valid_i) begin
      if (main_valid_q && !pop) begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end else begin
        main_d       = push_data_i;
        main_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  a_skid_implies_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("spare entry full while output register empty");

  a_spare_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !pop |=> skid_valid_q && $stable(skid_q))
    else $error("spare entry lost while output stalled");

  a_no_loss_on_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_i && push_ready_o && main_valid_q && !pop |=> skid_valid_q)
    else $error("pushed item dropped");

endmodule

// ===== hw/rtl/png_chunk_stream_parser_top.sv =====
// ----------------------------------------------------------------------------
// PNG chunk stream parser
// Checks the PNG signature and frames chunks from a byte stream, reporting
// each chunk's type and length, bad or short signatures and truncation.
// ----------------------------------------------------------------------------
// Throughput: one input item per clock cycle while the report side keeps up.
// Reports are registered in the output buffer before they reach out_o.
// The framing state updates in the accept cycle; a two-entry output buffer
// takes in_i.ready low only when both its entries hold untaken reports.
// Reset (rst_ni low, asynchronous): signature phase, counters, end flag clear,
// match flag set, output buffer empty. An end-of-file item returns the framing
// state to the same values and leaves queued reports in the buffer.
module png_chunk_stream_parser_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  png_csp_in_if.sink           in_i,
  png_csp_out_if.source        out_o
);

  typedef enum logic [5:0] {
    PH_SIG    = 6'b000001,
    PH_LEN    = 6'b000010,
    PH_TYPE   = 6'b000100,
    PH_DATA   = 6'b001000,
    PH_CRC    = 6'b010000,
    PH_IGNORE = 6'b100000
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [2:0]           cnt_q, cnt_d;
  logic                 sig_ok_q, sig_ok_d;
  logic [31:0]          len_q, len_d;
  logic [31:0]          type_q, type_d;
  logic [31:0]          rem_q, rem_d;
  logic                 end_seen_q, end_seen_d;

  logic                 acc;
  logic                 in_ready;
  logic                 res_valid;
  png_csp_pkg::result_t res;
  png_csp_pkg::result_t out_data;
  logic [4:0]           code;

  assign acc        = in_i.valid && in_ready;
  assign in_i.ready = in_ready;
  assign code       = png_csp_pkg::classify({type_q[23:0], in_i.data_byte});

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    sig_ok_d   = sig_ok_q;
    len_d      = len_q;
    type_d     = type_q;
    rem_d      = rem_q;
    end_seen_d = end_seen_q;
    res_valid  = 1'b0;
    res        = '0;
    if (acc) begin
      if (in_i.cmd) begin
        if (phase_q == PH_SIG) begin
          res_valid       = 1'b1;
          res.report_kind = png_csp_pkg::KIND_SHORT;
        end else if (phase_q != PH_IGNORE) begin
          res_valid       = 1'b1;
          res.report_kind = png_csp_pkg::KIND_TRUNC;
        end
        phase_d    = PH_SIG;
        cnt_d      = '0;
        sig_ok_d   = 1'b1;
        len_d      = '0;
        type_d     = '0;
        rem_d      = '0;
        end_seen_d = 1'b0;
      end else begin
        unique case (phase_q)
          PH_SIG: begin
            sig_ok_d = sig_ok_q && (in_i.data_byte == png_csp_pkg::SigBytes[cnt_q]);
            if (cnt_q == 3'(png_csp_pkg::SigLen - 1)) begin
              cnt_d = '0;
              if (sig_ok_d) begin
                phase_d = PH_LEN;
              end else begin
                res_valid       = 1'b1;
                res.report_kind = png_csp_pkg::KIND_BADSIG;
                phase_d         = PH_IGNORE;
              end
            end else begin
              cnt_d = cnt_q + 3'd1;
            end
          end
          PH_LEN: begin
            len_d = {len_q[23:0], in_i.data_byte};
            if (cnt_q == 3'd3) begin
              cnt_d   = '0;
              phase_d = PH_TYPE;
            end else begin
              cnt_d = cnt_q + 3'd1;
            end
          end
          PH_TYPE: begin
            type_d = {type_q[23:0], in_i.data_byte};
            if (cnt_q == 3'd3) begin
              cnt_d            = '0;
              res_valid        = 1'b1;
              res.report_kind  = png_csp_pkg::KIND_CHUNK;
              res.type_code    = code;
              res.type_word    = type_d;
              res.chunk_length = len_q;
              if (code == png_csp_pkg::IendCode) begin
                end_seen_d = 1'b1;
              end
              rem_d   = len_q;
              phase_d = (len_q == '0) ? PH_CRC : PH_DATA;
            end else begin
              cnt_d = cnt_q + 3'd1;
            end
          end
          PH_DATA: begin
            rem_d = rem_q - 32'd1;
            if (rem_q == 32'd1) begin
              phase_d = PH_CRC;
            end
          end
          PH_CRC: begin
            if (cnt_q == 3'd3) begin
              cnt_d   = '0;
              len_d   = '0;
              type_d  = '0;
              phase_d = end_seen_q ? PH_IGNORE : PH_LEN;
            end else begin
              cnt_d = cnt_q + 3'd1;
            end
          end
          PH_IGNORE: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SIG;
      cnt_q      <= '0;
      sig_ok_q   <= 1'b1;
      len_q      <= '0;
      type_q     <= '0;
      rem_q      <= '0;
      end_seen_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      sig_ok_q   <= sig_ok_d;
      len_q      <= len_d;
      type_q     <= type_d;
      rem_q      <= rem_d;
      end_seen_q <= end_seen_d;
    end
  end

  png_csp_skid u_skid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (res_valid),
    .push_ready_o (in_ready),
    .push_data_i  (res),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_data_o   (out_data)
  );

  assign out_o.report_kind  = out_data.report_kind;
  assign out_o.type_code    = out_data.type_code;
  assign out_o.type_word    = out_data.type_word;
  assign out_o.chunk_length = out_data.chunk_length;

  a_cnt_field_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_SIG |-> cnt_q < 3'd4)
    else $error("field byte count out of range");

  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> rem_q != '0)
    else $error("data phase with nothing left to skip");

  a_eof_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_i.cmd |=> phase_q == PH_SIG && cnt_q == '0 && !end_seen_q)
    else $error("end of file did not return to signature phase");

  a_end_after_sig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_seen_q |-> phase_q != PH_SIG && sig_ok_q)
    else $error("end chunk flag set without a valid signature");

endmodule
